>>> hdl/sorted_integer_set_table_unit_macros.svh
// assertion macros for the sorted integer set table checker
`ifndef SORTED_INTEGER_SET_TABLE_UNIT_MACROS_SVH
`define SORTED_INTEGER_SET_TABLE_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define SIST_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define SIST_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/sist_pkg.sv
// types, constants and codes shared by the sorted integer set table
package sist_pkg;

  localparam int CAPACITY  = 256;
  localparam int KEY_WIDTH = 32;
  localparam int VALUE_W   = 32;
  localparam int ADDR_W    = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);

  typedef logic [KEY_WIDTH-1:0] key_t;
  typedef logic [ADDR_W-1:0]    addr_t;
  typedef logic [CNT_W-1:0]     cnt_t;

  localparam key_t KEY_SIGN = key_t'(1) << (KEY_WIDTH - 1);
  localparam cnt_t CNT_FULL = cnt_t'(CAPACITY);

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_MEMBER = 2'd1,
    ACT_DELETE = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_DUP    = 2'd1,
    STAT_ABSENT = 2'd2,
    STAT_FULL   = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEARCH,
    S_CMP,
    S_INS,
    S_INS_TAIL,
    S_INS_KEY,
    S_DEL,
    S_DEL_TAIL,
    S_DONE
  } state_t;

  typedef struct packed {
    logic  we;
    addr_t waddr;
    key_t  wdata;
    addr_t raddr;
  } mem_req_t;

  typedef struct packed {
    logic    vld;
    status_t status;
    cnt_t    count;
  } res_t;

endpackage

>>> hdl/sist_mem.sv
// entry memory: one write port, one registered read port
module sist_mem
  import sist_pkg::*;
(
  input  logic     clk,
  input  mem_req_t req,
  output key_t     rd_data
);

  key_t mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[req.raddr];
  end

endmodule

>>> hdl/sist_ctrl.sv
// sequencer: binary search over the memory, then for insert and delete shift entries one per cycle
module sist_ctrl
  import sist_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic [1:0]                in_action,
  input  logic signed [VALUE_W-1:0] in_value,
  output logic                      in_ready,
  input  key_t                      rd_data,
  output mem_req_t                  mem_req,
  output res_t                      res,
  input  logic                      res_ready
);

  state_t     state_r, state_nxt;
  cnt_t       held_r, held_nxt;
  logic       wb_vld_r, wb_vld_nxt;
  addr_t      wb_addr_r, wb_addr_nxt;
  addr_t      idx_r, idx_nxt;
  cnt_t       lo_r, lo_nxt;
  cnt_t       hi_r, hi_nxt;
  cnt_t       mid_r, mid_nxt;
  logic       found_r, found_nxt;
  key_t       key_r, key_nxt;
  logic [1:0] act_r, act_nxt;
  status_t    status_r, status_nxt;

  logic           accept;
  logic           search_done;
  logic [CNT_W:0] mid_sum;
  cnt_t           mid_w;
  cnt_t           lo_p1;
  cnt_t           held_m1;
  addr_t          pos;

  assign accept      = in_valid && in_ready;
  assign search_done = (lo_r >= hi_r);
  assign mid_sum     = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid_w       = mid_sum[CNT_W:1];
  assign lo_p1       = lo_r + cnt_t'(1);
  assign held_m1     = held_r - cnt_t'(1);
  assign pos         = lo_r[ADDR_W-1:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (!search_done) begin
          state_nxt = S_CMP;
        end else begin
          case (action_t'(act_r))
            ACT_INSERT: begin
              if (found_r || held_r == CNT_FULL) begin
                state_nxt = S_DONE;
              end else if (lo_r == held_r) begin
                state_nxt = S_INS_KEY;
              end else begin
                state_nxt = S_INS;
              end
            end
            ACT_DELETE: begin
              if (!found_r) begin
                state_nxt = S_DONE;
              end else if (lo_p1 == held_r) begin
                state_nxt = S_DEL_TAIL;
              end else begin
                state_nxt = S_DEL;
              end
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_CMP:      state_nxt = S_SEARCH;
      S_INS: begin
        if (idx_r == pos) begin
          state_nxt = S_INS_TAIL;
        end
      end
      S_INS_TAIL: state_nxt = S_INS_KEY;
      S_INS_KEY:  state_nxt = S_DONE;
      S_DEL: begin
        if (idx_r == held_m1[ADDR_W-1:0]) begin
          state_nxt = S_DEL_TAIL;
        end
      end
      S_DEL_TAIL: state_nxt = S_DONE;
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default:    state_nxt = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    held_nxt    = held_r;
    wb_vld_nxt  = 1'b0;
    wb_addr_nxt = wb_addr_r;
    idx_nxt     = idx_r;
    lo_nxt      = lo_r;
    hi_nxt      = hi_r;
    mid_nxt     = mid_r;
    found_nxt   = found_r;
    key_nxt     = key_r;
    act_nxt     = act_r;
    status_nxt  = status_r;

    mem_req.we    = wb_vld_r;
    mem_req.waddr = wb_addr_r;
    mem_req.wdata = rd_data;
    mem_req.raddr = mid_w[ADDR_W-1:0];

    in_ready   = (state_r == S_IDLE);
    res.vld    = (state_r == S_DONE);
    res.status = status_r;
    res.count  = held_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          key_nxt   = key_t'(in_value[KEY_WIDTH-1:0]) ^ KEY_SIGN;
          act_nxt   = in_action;
          lo_nxt    = '0;
          hi_nxt    = held_r;
          found_nxt = 1'b0;
        end
      end
      S_SEARCH: begin
        mid_nxt = mid_w;
        if (search_done) begin
          case (action_t'(act_r))
            ACT_INSERT: begin
              if (found_r) begin
                status_nxt = STAT_DUP;
              end else if (held_r == CNT_FULL) begin
                status_nxt = STAT_FULL;
              end else begin
                idx_nxt = held_m1[ADDR_W-1:0];
              end
            end
            ACT_DELETE: begin
              status_nxt = found_r ? STAT_OK : STAT_ABSENT;
              idx_nxt    = lo_p1[ADDR_W-1:0];
            end
            default: status_nxt = found_r ? STAT_OK : STAT_ABSENT;
          endcase
        end
      end
      S_CMP: begin
        if (rd_data < key_r) begin
          lo_nxt = mid_r + cnt_t'(1);
        end else begin
          hi_nxt = mid_r;
        end
        if (rd_data == key_r) begin
          found_nxt = 1'b1;
        end
      end
      S_INS: begin
        mem_req.raddr = idx_r;
        wb_vld_nxt    = 1'b1;
        wb_addr_nxt   = idx_r + addr_t'(1);
        idx_nxt       = idx_r - addr_t'(1);
      end
      S_INS_TAIL: ;
      S_INS_KEY: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = pos;
        mem_req.wdata = key_r;
        held_nxt      = held_r + cnt_t'(1);
        status_nxt    = STAT_OK;
      end
      S_DEL: begin
        mem_req.raddr = idx_r;
        wb_vld_nxt    = 1'b1;
        wb_addr_nxt   = idx_r - addr_t'(1);
        idx_nxt       = idx_r + addr_t'(1);
      end
      S_DEL_TAIL: begin
        held_nxt = held_m1;
      end
      S_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      held_r   <= '0;
      wb_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      held_r   <= held_nxt;
      wb_vld_r <= wb_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wb_addr_r <= wb_addr_nxt;
    idx_r     <= idx_nxt;
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    mid_r     <= mid_nxt;
    found_r   <= found_nxt;
    key_r     <= key_nxt;
    act_r     <= act_nxt;
    status_r  <= status_nxt;
  end

endmodule

>>> hdl/sorted_integer_set_table_unit.sv
// membership test: a binary search over the held values, each probe a registered memory read
// in S_SEARCH and a compare in S_CMP; insert and delete then move the entries from the found
// position on one by one. One item at a time: the next is taken in the cycle after the result
// enters the output register, where it may wait
// reset: synchronous active-low rst_n empties the set at once, no memory clearing pass
// top level of the sorted integer set table
module sorted_integer_set_table_unit
  import sist_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                in_action,
  input  logic signed [VALUE_W-1:0] in_value,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [1:0]                out_status,
  output cnt_t                      out_entry_count
);

  mem_req_t mem_req;
  key_t     rd_data;
  res_t     res;
  logic     res_ready;

  logic       out_valid_r;
  logic [1:0] out_status_r;
  cnt_t       out_count_r;

  sist_mem u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  sist_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .in_value  (in_value),
    .in_ready  (in_ready),
    .rd_data   (rd_data),
    .mem_req   (mem_req),
    .res       (res),
    .res_ready (res_ready)
  );

  // output register
  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res.vld) begin
      out_status_r <= res.status;
      out_count_r  <= res.count;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_entry_count = out_count_r;

endmodule

>>> hdl/sist_checker.sv
// port-level checker for the sorted integer set table, bound to the top level
`include "sorted_integer_set_table_unit_macros.svh"

module sist_checker
  import sist_pkg::*;
(
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic [1:0]                in_action,
  input logic signed [VALUE_W-1:0] in_value,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [1:0]                out_status,
  input cnt_t                      out_entry_count
);

  `SIST_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_entry_count), "result item dropped or changed while stalled")
  `SIST_ASSERT_NOW(a_full_count, out_valid && out_status == STAT_FULL, out_entry_count == CNT_FULL, "table full reported below capacity")
  `SIST_ASSERT_NOW(a_dup_count, out_valid && out_status == STAT_DUP, out_entry_count != '0, "duplicate reported on an empty set")
  `SIST_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "second item taken while one is at work")

endmodule

bind sorted_integer_set_table_unit sist_checker u_sist_checker (.*);
